FILE: rtl/core/rves_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the vertical rocket Euler step block.
package rves_pkg;

   localparam int Q_W       = 48;
   localparam int CSR_IDX_W = 3;

   typedef logic [Q_W-1:0]       q48_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [16:0]          throttle_type;

   // Configuration register indexes
   localparam csr_idx_type CSR_DRY_MASS    = 3'd0;
   localparam csr_idx_type CSR_PROP_MASS   = 3'd1;
   localparam csr_idx_type CSR_MAX_THRUST  = 3'd2;
   localparam csr_idx_type CSR_SPEC_IMP    = 3'd3;
   localparam csr_idx_type CSR_GRAVITY     = 3'd4;
   localparam csr_idx_type CSR_TIME_STEP   = 3'd5;

   // Reset values of the configuration and of the vehicle mass
   localparam q48_type     RST_DRY_MASS   = 48'd131072000;
   localparam q48_type     RST_PROP_MASS  = 48'd655360000;
   localparam q48_type     RST_MAX_THRUST = 48'd9830400000;
   localparam logic [31:0] RST_SPEC_IMP   = 32'd19660800;
   localparam logic [23:0] RST_GRAVITY    = 24'd642908;
   localparam logic [15:0] RST_TIME_STEP  = 16'd655;
   localparam q48_type     RST_MASS       = 48'd786432000;

   // Standard gravity 9.81 in Q4.16, used for propellant flow only
   localparam logic [19:0] G0_Q816 = 20'd642908;

   localparam throttle_type THROTTLE_FULL = 17'd65536;

   localparam q48_type U48_MAX = 48'hFFFF_FFFF_FFFF;
   localparam q48_type SMAX48  = 48'h7FFF_FFFF_FFFF;
   localparam q48_type SMIN48  = 48'h8000_0000_0000;

   // Last step index of each serial phase
   localparam logic [6:0] FORCE_LAST = 7'd23;
   localparam logic [6:0] FLOW_LAST  = 7'd19;
   localparam logic [6:0] DIV_LAST   = 7'd79;
   localparam logic [6:0] SCALE_LAST = 7'd15;

   // Clamp a 49-bit signed sum to the signed 48-bit range
   function automatic q48_type sat_s48(input logic [Q_W:0] v);
      q48_type r;
      if (v[Q_W] != v[Q_W-1]) begin
         r = v[Q_W] ? SMIN48 : SMAX48;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/rocket_vertical_euler_step_top.sv
`timescale 1ns / 1ps
// Vertical rocket state integrator: one explicit Euler step per tick, bit-serial datapath.
//
// A throttle command (req_tuser = 0) is clamped to 0..1.0 and stored, and gives no
// response. A tick (req_tuser = 1) runs one Euler step and returns altitude,
// velocity and mass. A tick occupies the block from its transfer until its result is
// registered, and no new item is taken meanwhile; the block also waits before that
// while rsp_tready is held low and an earlier result is still unsent. The time is set
// by the shift-add multipliers, one multiplier bit per cycle (for thrust and weight,
// for flow and its divisor, and for the two dt scalings), and above all by the two
// restoring dividers for propellant flow and acceleration, which run side by side and
// retire one quotient bit per cycle over an 80-bit dividend. Any write to a used
// configuration index resets altitude and velocity to zero and mass to dry plus
// propellant mass; writes are taken only while no tick is in progress.
module rocket_vertical_euler_step_top
   import rves_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [17:0] throttle_command, [23:18] zero
   input  logic                 req_tuser,   // [0] action
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [143:0]         rsp_tdata,   // [47:0] altitude, [95:48] velocity,
                                             // [143:96] vehicle_mass
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_FORCE   = 4'd1;
   localparam logic [3:0] ST_LD_FLOW = 4'd2;
   localparam logic [3:0] ST_FLOW    = 4'd3;
   localparam logic [3:0] ST_LD_DIV  = 4'd4;
   localparam logic [3:0] ST_DIVIDE  = 4'd5;
   localparam logic [3:0] ST_LD_VEL  = 4'd6;
   localparam logic [3:0] ST_VEL     = 4'd7;
   localparam logic [3:0] ST_UPD_VEL = 4'd8;
   localparam logic [3:0] ST_LD_ALT  = 4'd9;
   localparam logic [3:0] ST_ALT     = 4'd10;
   localparam logic [3:0] ST_UPD_ALT = 4'd11;
   localparam logic [3:0] ST_FINISH  = 4'd12;

   // control and architectural state
   logic [3:0]   state_ff, state_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   q48_type      dry_ff, dry_in;
   q48_type      prop_ff, prop_in;
   q48_type      max_thrust_ff, max_thrust_in;
   logic [31:0]  isp_ff, isp_in;
   logic [23:0]  grav_ff, grav_in;
   logic [15:0]  dt_ff, dt_in;
   throttle_type throttle_ff, throttle_in;
   q48_type      alt_ff, alt_in;
   q48_type      vel_ff, vel_in;
   q48_type      mass_ff, mass_in;

   // datapath
   q48_type      a_acc_ff, a_acc_in;
   logic [23:0]  a_mul_ff, a_mul_in;
   q48_type      a_mcand_ff, a_mcand_in;
   q48_type      b_acc_ff, b_acc_in;
   logic [23:0]  b_mul_ff, b_mul_in;
   q48_type      b_mcand_ff, b_mcand_in;
   logic [51:0]  d1_rem_ff, d1_rem_in;
   logic [79:0]  d1_quo_ff, d1_quo_in;
   logic [51:0]  d1_den_ff, d1_den_in;
   q48_type      d2_rem_ff, d2_rem_in;
   logic [79:0]  d2_quo_ff, d2_quo_in;
   logic         burn_ff, burn_in;
   q48_type      thrust_ff, thrust_in;
   q48_type      weight_ff, weight_in;
   logic         net_neg_ff, net_neg_in;
   logic         net_zero_ff, net_zero_in;
   logic         neg_ff, neg_in;
   q48_type      dm_ff, dm_in;
   logic [143:0] rsp_data_ff, rsp_data_in;

   logic         csr_fire;
   logic         req_fire;
   logic         csr_hit;
   logic [Q_W:0] init_mass;
   logic [Q_W:0] a_sum;
   logic [Q_W:0] b_sum;
   logic [52:0]  d1_t;
   logic [52:0]  d1_diff;
   logic         d1_ge;
   logic [Q_W:0] d2_t;
   logic [Q_W:0] d2_diff;
   logic         d2_ge;
   logic [55:0]  force_a;
   logic [55:0]  force_b;
   logic [63:0]  flow_p;
   logic [51:0]  flow_den;
   logic         tw_ge;
   q48_type      net_mag;
   q48_type      accel_mag;
   logic         d2_ovf;
   logic [Q_W:0] vel_sum;
   logic [Q_W:0] alt_sum;
   q48_type      mass_left;
   q48_type      vel_abs;
   logic         grounded;

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shift-add multiplier steps, one multiplier bit per cycle
   assign a_sum = {1'b0, a_acc_ff} + (a_mul_ff[0] ? {1'b0, a_mcand_ff} : '0);
   assign b_sum = {1'b0, b_acc_ff} + (b_mul_ff[0] ? {1'b0, b_mcand_ff} : '0);

   // restoring divider steps, one quotient bit per cycle
   assign d1_t    = {d1_rem_ff, d1_quo_ff[79]};
   assign d1_ge   = d1_t >= {1'b0, d1_den_ff};
   assign d1_diff = d1_t - {1'b0, d1_den_ff};
   assign d2_t    = {d2_rem_ff, d2_quo_ff[79]};
   assign d2_ge   = d2_t >= {1'b0, mass_ff};
   assign d2_diff = d2_t - {1'b0, mass_ff};

   // product views: low product bits sit at the top of the multiplier register
   assign force_a  = {a_acc_ff, a_mul_ff[23:16]};
   assign force_b  = {b_acc_ff, b_mul_ff[23:16]};
   assign flow_p   = {a_acc_ff[43:0], a_mul_ff[23:4]};
   assign flow_den = {b_acc_ff[31:0], b_mul_ff[23:4]};

   assign tw_ge   = thrust_ff >= weight_ff;
   assign net_mag = tw_ge ? (thrust_ff - weight_ff) : (weight_ff - thrust_ff);

   assign d2_ovf = |d2_quo_ff[79:48];
   always_comb begin
      if (net_zero_ff) begin
         accel_mag = '0;
      end else if (!net_neg_ff) begin
         accel_mag = (d2_ovf || d2_quo_ff[47]) ? SMAX48 : {1'b0, d2_quo_ff[46:0]};
      end else begin
         accel_mag = (d2_ovf || (d2_quo_ff[47] && (|d2_quo_ff[46:0]))) ?
                     SMIN48 : d2_quo_ff[47:0];
      end
   end

   assign vel_sum = neg_ff ? ({vel_ff[Q_W-1], vel_ff} - {1'b0, a_acc_ff})
                           : ({vel_ff[Q_W-1], vel_ff} + {1'b0, a_acc_ff});
   assign alt_sum = neg_ff ? ({alt_ff[Q_W-1], alt_ff} - {1'b0, a_acc_ff})
                           : ({alt_ff[Q_W-1], alt_ff} + {1'b0, a_acc_ff});
   assign mass_left = (dm_ff >= mass_ff) ? '0 : (mass_ff - dm_ff);
   assign vel_abs   = vel_ff[Q_W-1] ? (q48_type'(0) - vel_ff) : vel_ff;
   assign grounded  = alt_ff[Q_W-1] || (alt_ff == '0);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      dry_in        = dry_ff;
      prop_in       = prop_ff;
      max_thrust_in = max_thrust_ff;
      isp_in        = isp_ff;
      grav_in       = grav_ff;
      dt_in         = dt_ff;
      throttle_in   = throttle_ff;
      alt_in        = alt_ff;
      vel_in        = vel_ff;
      mass_in       = mass_ff;
      a_acc_in      = a_acc_ff;
      a_mul_in      = a_mul_ff;
      a_mcand_in    = a_mcand_ff;
      b_acc_in      = b_acc_ff;
      b_mul_in      = b_mul_ff;
      b_mcand_in    = b_mcand_ff;
      d1_rem_in     = d1_rem_ff;
      d1_quo_in     = d1_quo_ff;
      d1_den_in     = d1_den_ff;
      d2_rem_in     = d2_rem_ff;
      d2_quo_in     = d2_quo_ff;
      burn_in       = burn_ff;
      thrust_in     = thrust_ff;
      weight_in     = weight_ff;
      net_neg_in    = net_neg_ff;
      net_zero_in   = net_zero_ff;
      neg_in        = neg_ff;
      dm_in         = dm_ff;
      rsp_data_in   = rsp_data_ff;
      csr_hit       = 1'b0;
      init_mass     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               csr_hit = 1'b1;
               case (csr_index)
                  CSR_DRY_MASS:   dry_in        = csr_data;
                  CSR_PROP_MASS:  prop_in       = csr_data;
                  CSR_MAX_THRUST: max_thrust_in = csr_data;
                  CSR_SPEC_IMP:   isp_in        = csr_data[31:0];
                  CSR_GRAVITY:    grav_in       = csr_data[23:0];
                  CSR_TIME_STEP:  dt_in         = csr_data[15:0];
                  default:        csr_hit       = 1'b0;
               endcase
               init_mass = {1'b0, dry_in} + {1'b0, prop_in};
               if (csr_hit) begin
                  alt_in  = '0;
                  vel_in  = '0;
                  mass_in = init_mass[Q_W] ? U48_MAX : init_mass[Q_W-1:0];
               end
            end else if (req_fire) begin
               if (!req_tuser) begin
                  // negative clamps to zero, anything from 1.0 up to full
                  if (req_tdata[17]) begin
                     throttle_in = '0;
                  end else if (req_tdata[16]) begin
                     throttle_in = THROTTLE_FULL;
                  end else begin
                     throttle_in = {1'b0, req_tdata[15:0]};
                  end
               end else begin
                  burn_in    = (mass_ff > dry_ff) && (throttle_ff != '0);
                  a_acc_in   = '0;
                  a_mcand_in = ((mass_ff > dry_ff) && (throttle_ff != '0)) ?
                               max_thrust_ff : '0;
                  a_mul_in   = {7'b0, throttle_ff};
                  b_acc_in   = '0;
                  b_mcand_in = mass_ff;
                  b_mul_in   = grav_ff;
                  cnt_in     = '0;
                  state_in   = ST_FORCE;
               end
            end
         end

         ST_FORCE, ST_FLOW: begin
            a_acc_in = a_sum[Q_W:1];
            a_mul_in = {a_sum[0], a_mul_ff[23:1]};
            b_acc_in = b_sum[Q_W:1];
            b_mul_in = {b_sum[0], b_mul_ff[23:1]};
            cnt_in   = cnt_ff + 7'd1;
            if (state_ff == ST_FORCE && cnt_ff == FORCE_LAST) begin
               state_in = ST_LD_FLOW;
            end else if (state_ff == ST_FLOW && cnt_ff == FLOW_LAST) begin
               state_in = ST_LD_DIV;
            end
         end

         ST_LD_FLOW: begin
            thrust_in  = force_a[Q_W-1:0];
            weight_in  = (|force_b[55:48]) ? U48_MAX : force_b[Q_W-1:0];
            a_acc_in   = '0;
            a_mcand_in = force_a[Q_W-1:0];
            a_mul_in   = {8'b0, dt_ff};
            b_acc_in   = '0;
            b_mcand_in = {16'b0, isp_ff};
            b_mul_in   = {4'b0, G0_Q816};
            cnt_in     = '0;
            state_in   = ST_FLOW;
         end

         ST_LD_DIV: begin
            d1_rem_in   = '0;
            d1_quo_in   = {flow_p, 16'b0};
            d1_den_in   = flow_den;
            d2_rem_in   = '0;
            d2_quo_in   = {16'b0, net_mag, 16'b0};
            net_neg_in  = !tw_ge;
            net_zero_in = (thrust_ff == weight_ff);
            cnt_in      = '0;
            state_in    = ST_DIVIDE;
         end

         ST_DIVIDE: begin
            d1_rem_in = d1_ge ? d1_diff[51:0] : d1_t[51:0];
            d1_quo_in = {d1_quo_ff[78:0], d1_ge};
            d2_rem_in = d2_ge ? d2_diff[Q_W-1:0] : d2_t[Q_W-1:0];
            d2_quo_in = {d2_quo_ff[78:0], d2_ge};
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_LD_VEL;
            end
         end

         ST_LD_VEL: begin
            // no burn means no flow, even when the divisor is zero
            if (!burn_ff) begin
               dm_in = '0;
            end else begin
               dm_in = (|d1_quo_ff[79:48]) ? U48_MAX : d1_quo_ff[47:0];
            end
            a_acc_in   = '0;
            a_mcand_in = accel_mag;
            a_mul_in   = {8'b0, dt_ff};
            neg_in     = net_neg_ff;
            cnt_in     = '0;
            state_in   = ST_VEL;
         end

         ST_VEL, ST_ALT: begin
            a_acc_in = a_sum[Q_W:1];
            a_mul_in = {a_sum[0], a_mul_ff[23:1]};
            cnt_in   = cnt_ff + 7'd1;
            if (cnt_ff == SCALE_LAST) begin
               state_in = (state_ff == ST_VEL) ? ST_UPD_VEL : ST_UPD_ALT;
            end
         end

         ST_UPD_VEL: begin
            vel_in   = sat_s48(vel_sum);
            mass_in  = mass_left;
            state_in = ST_LD_ALT;
         end

         ST_LD_ALT: begin
            if (mass_ff < dry_ff) begin
               mass_in = dry_ff;
            end
            a_acc_in   = '0;
            a_mcand_in = vel_abs;
            a_mul_in   = {8'b0, dt_ff};
            neg_in     = vel_ff[Q_W-1];
            cnt_in     = '0;
            state_in   = ST_ALT;
         end

         ST_UPD_ALT: begin
            alt_in   = sat_s48(alt_sum);
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // hold until the output slot is free, then land the vehicle if needed
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (grounded) begin
                  alt_in      = '0;
                  vel_in      = '0;
                  rsp_data_in = {mass_ff, 48'b0, 48'b0};
               end else begin
                  rsp_data_in = {mass_ff, vel_ff, alt_ff};
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         dry_ff        <= RST_DRY_MASS;
         prop_ff       <= RST_PROP_MASS;
         max_thrust_ff <= RST_MAX_THRUST;
         isp_ff        <= RST_SPEC_IMP;
         grav_ff       <= RST_GRAVITY;
         dt_ff         <= RST_TIME_STEP;
         throttle_ff   <= '0;
         alt_ff        <= '0;
         vel_ff        <= '0;
         mass_ff       <= RST_MASS;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         dry_ff        <= dry_in;
         prop_ff       <= prop_in;
         max_thrust_ff <= max_thrust_in;
         isp_ff        <= isp_in;
         grav_ff       <= grav_in;
         dt_ff         <= dt_in;
         throttle_ff   <= throttle_in;
         alt_ff        <= alt_in;
         vel_ff        <= vel_in;
         mass_ff       <= mass_in;
      end
   end

   always_ff @(posedge clock) begin
      a_acc_ff    <= a_acc_in;
      a_mul_ff    <= a_mul_in;
      a_mcand_ff  <= a_mcand_in;
      b_acc_ff    <= b_acc_in;
      b_mul_ff    <= b_mul_in;
      b_mcand_ff  <= b_mcand_in;
      d1_rem_ff   <= d1_rem_in;
      d1_quo_ff   <= d1_quo_in;
      d1_den_ff   <= d1_den_in;
      d2_rem_ff   <= d2_rem_in;
      d2_quo_ff   <= d2_quo_in;
      burn_ff     <= burn_in;
      thrust_ff   <= thrust_in;
      weight_ff   <= weight_in;
      net_neg_ff  <= net_neg_in;
      net_zero_ff <= net_zero_in;
      neg_ff      <= neg_in;
      dm_ff       <= dm_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: bench/rves_euler_checker.sv
`timescale 1ns / 1ps
// Checker for the rocket Euler step block: tracks vehicle state, predicts each tick, compares.
module rves_euler_checker
   import rves_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [17:0] throttle_command, [23:18] zero
   input  logic                 req_tuser,   // [0] action
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [143:0]         rsp_tdata,   // [47:0] altitude, [95:48] velocity,
                                             // [143:96] vehicle_mass
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_data,
   output int                   mismatches,
   output int                   pending,
   output int                   compared
);

   localparam logic ACT_TICK  = 1'b1;

   // Same layout as rsp_tdata: altitude in the low bits
   typedef struct packed {
      q48_type mass;
      q48_type vel;
      q48_type alt;
   } vehicle_state_type;

   q48_type      cfg_dry, cfg_prop, cfg_thrust;
   logic [31:0]  cfg_isp;
   logic [23:0]  cfg_grav;
   logic [15:0]  cfg_dt;
   throttle_type cmd_throttle;
   q48_type      veh_alt, veh_vel, veh_mass;

   vehicle_state_type predicted_states[$];
   int err_count = 0;
   int cmp_count = 0;

   // trunc(v * dt / 2^16), rounding toward zero on the magnitude
   function automatic q48_type scale_by_dt(q48_type v, logic [15:0] step);
      q48_type     mag;
      logic [63:0] prod;
      mag  = v[Q_W-1] ? 48'd0 - v : v;
      prod = mag * step;
      prod = prod >> 16;
      return v[Q_W-1] ? 48'd0 - prod[Q_W-1:0] : prod[Q_W-1:0];
   endfunction

   function automatic q48_type clamp_add(q48_type a, q48_type b);
      logic [Q_W:0] s;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? SMIN48 : SMAX48;
      return s[Q_W-1:0];
   endfunction

   task automatic refill_vehicle();
      logic [Q_W:0] total;
      total    = cfg_dry + cfg_prop;
      veh_alt  = '0;
      veh_vel  = '0;
      veh_mass = total[Q_W] ? U48_MAX : total[Q_W-1:0];
   endtask

   task automatic integrate_tick(output vehicle_state_type outcome);
      logic [64:0] thrust_prod;
      logic [71:0] weight_prod;
      logic [63:0] flow_prod, isp_g0, accel_quot;
      logic [79:0] flow_quot;
      q48_type     thrust, weight, burn, net_mag, accel, remain;
      logic        net_neg;
      thrust = '0;
      burn   = '0;
      if (veh_mass > cfg_dry && cmd_throttle != 0) begin
         thrust_prod = cmd_throttle * cfg_thrust;
         thrust      = thrust_prod[64] ? U48_MAX : thrust_prod[63:16];
         flow_prod   = thrust * cfg_dt;
         isp_g0      = cfg_isp * G0_Q816;
         if (isp_g0 == 0) begin
            burn = U48_MAX;
         end else begin
            flow_quot = {flow_prod, 16'd0} / isp_g0;
            burn      = (|flow_quot[79:48]) ? U48_MAX : flow_quot[Q_W-1:0];
         end
      end
      weight_prod = veh_mass * cfg_grav;
      weight      = (|weight_prod[71:64]) ? U48_MAX : weight_prod[63:16];
      net_neg     = weight > thrust;
      net_mag     = net_neg ? weight - thrust : thrust - weight;
      if (veh_mass == 0) begin
         if (net_mag == 0) accel = '0;
         else accel = net_neg ? SMIN48 : SMAX48;
      end else begin
         accel_quot = {net_mag, 16'd0} / veh_mass;
         if (net_neg) begin
            accel = (accel_quot > 64'h8000_0000_0000) ? SMIN48 : 48'd0 - accel_quot[Q_W-1:0];
         end else begin
            accel = (accel_quot > {16'd0, SMAX48}) ? SMAX48 : accel_quot[Q_W-1:0];
         end
      end
      veh_vel  = clamp_add(veh_vel, scale_by_dt(accel, cfg_dt));
      veh_alt  = clamp_add(veh_alt, scale_by_dt(veh_vel, cfg_dt));
      remain   = (burn >= veh_mass) ? '0 : veh_mass - burn;
      veh_mass = (remain < cfg_dry) ? cfg_dry : remain;
      // on or below the pad: sit still
      if (veh_alt[Q_W-1] || veh_alt == 0) begin
         veh_alt = '0;
         veh_vel = '0;
      end
      outcome.alt  = veh_alt;
      outcome.vel  = veh_vel;
      outcome.mass = veh_mass;
   endtask

   task automatic check_field(string label, q48_type want, q48_type seen);
      if (seen !== want) begin
         err_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, seen);
      end
   endtask

   always @(posedge clock) begin
      vehicle_state_type want, seen;
      if (reset) begin
         cfg_dry      = RST_DRY_MASS;
         cfg_prop     = RST_PROP_MASS;
         cfg_thrust   = RST_MAX_THRUST;
         cfg_isp      = RST_SPEC_IMP;
         cfg_grav     = RST_GRAVITY;
         cfg_dt       = RST_TIME_STEP;
         cmd_throttle = '0;
         refill_vehicle();
         predicted_states.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (predicted_states.size() == 0) begin
               err_count++;
               $display("%0t: unexpected result transfer: expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = predicted_states.pop_front();
               cmp_count++;
               check_field("altitude", want.alt, seen.alt);
               check_field("velocity", want.vel, seen.vel);
               check_field("vehicle_mass", want.mass, seen.mass);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DRY_MASS:   cfg_dry    = csr_data;
               CSR_PROP_MASS:  cfg_prop   = csr_data;
               CSR_MAX_THRUST: cfg_thrust = csr_data;
               CSR_SPEC_IMP:   cfg_isp    = csr_data[31:0];
               CSR_GRAVITY:    cfg_grav   = csr_data[23:0];
               CSR_TIME_STEP:  cfg_dt     = csr_data[15:0];
               default: ;
            endcase
            // writes to unused indexes leave the vehicle alone
            if (csr_index <= CSR_TIME_STEP) refill_vehicle();
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_TICK) begin
               integrate_tick(want);
               predicted_states.push_back(want);
            end else if (req_tdata[17]) begin
               cmd_throttle = '0;
            end else if (req_tdata[16:0] > THROTTLE_FULL) begin
               cmd_throttle = THROTTLE_FULL;
            end else begin
               cmd_throttle = req_tdata[16:0];
            end
         end
      end
      mismatches <= err_count;
      pending    <= predicted_states.size();
      compared   <= cmp_count;
   end

endmodule

FILE: bench/tb_rocket_vertical_euler_step_top.sv
`timescale 1ns / 1ps
// Testbench top for the rocket Euler step block: stimulus, settings sweep and verdict.
module tb_rocket_vertical_euler_step_top;
   import rves_pkg::*;

   localparam logic        ACT_THROTTLE  = 1'b0;
   localparam logic        ACT_TICK      = 1'b1;
   localparam csr_idx_type CSR_SPARE_6   = 3'd6;
   localparam csr_idx_type CSR_SPARE_7   = 3'd7;
   // a tick holds the block for its whole step; allow for the settle pause and long stalls
   localparam int          QUIET_LIMIT   = 5000;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          NUM_SETTINGS  = 12;
   localparam int          ITEMS_EACH    = 135;

   logic           clock      = 1'b0;
   logic           reset      = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [23:0]    req_tdata  = '0;
   logic           req_tuser  = 1'b0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [143:0]   rsp_tdata;
   logic           csr_valid  = 1'b0;
   logic           csr_ready;
   csr_idx_type    csr_index  = '0;
   q48_type        csr_data   = '0;

   int mismatches, pending, compared;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int tick_count   = 0;
   int cmd_count    = 0;
   int write_count  = 0;
   int quiet_cycles = 0;

   rocket_vertical_euler_step_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rves_euler_checker vehicle_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .compared   (compared)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending);
         $display("tb_rocket_vertical_euler_step_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic q48_type rand48();
      return {$urandom, 16'($urandom)};
   endfunction

   // Set random bits above a narrow register's width half the time
   function automatic q48_type spill(q48_type v, int width);
      q48_type above;
      above = ~((q48_type'(1) << width) - 1);
      return ($urandom_range(1) == 1) ? (v | (rand48() & above)) : v;
   endfunction

   function automatic logic [5:0] pick_pad();
      return ($urandom_range(99) < 20) ? 6'($urandom) : 6'd0;
   endfunction

   function automatic logic [17:0] pick_throttle();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 18'($urandom_range(0, 65536));
      if (r < 65) return 18'd65536;
      if (r < 75) return 18'd0;
      return 18'($urandom);
   endfunction

   // Leave req_tvalid high after the transfer; the next gap or the caller drops it
   task automatic push_item(logic action, logic [17:0] field, logic [5:0] pad);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {pad, field};
      do @(posedge clock); while (!req_tready);
      if (action == ACT_TICK) tick_count++;
      else cmd_count++;
   endtask

   // Wait for every result, then for the block to finish any trailing command
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, q48_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      write_count++;
   endtask

   task automatic write_plausible();
      int r;
      write_reg(CSR_DRY_MASS, {16'd0, 16'($urandom_range(100, 50000)), 16'($urandom)});
      if ($urandom_range(3) == 0)
         write_reg(CSR_PROP_MASS, {16'd0, 16'($urandom_range(0, 20)), 16'($urandom)});
      else
         write_reg(CSR_PROP_MASS, {14'd0, 18'($urandom_range(0, 200000)), 16'($urandom)});
      write_reg(CSR_MAX_THRUST, {10'd0, 22'($urandom_range(0, 4000000)), 16'($urandom)});
      write_reg(CSR_SPEC_IMP,
                spill({16'd0, 16'($urandom_range(50, 450)), 16'($urandom)}, 32));
      if ($urandom_range(9) < 3)
         write_reg(CSR_GRAVITY, spill(48'($urandom_range(0, 24'hFF_FFFF)), 24));
      else
         write_reg(CSR_GRAVITY, spill(48'($urandom_range(65536, 20 * 65536)), 24));
      r = $urandom_range(9);
      if (r < 5)      write_reg(CSR_TIME_STEP, spill(48'($urandom_range(1, 65535)), 16));
      else if (r < 7) write_reg(CSR_TIME_STEP, spill(48'($urandom_range(1, 100)), 16));
      else            write_reg(CSR_TIME_STEP, spill(48'd655, 16));
   endtask

   task automatic configure(int setting);
      case (setting)
         1: begin
            // empty vehicle: no mass at all
            write_reg(CSR_DRY_MASS, '0);
            write_reg(CSR_PROP_MASS, '0);
         end
         2: begin
            write_plausible();
            write_reg(CSR_SPEC_IMP, spill(48'd0, 32));
         end
         3: begin
            // tiny vehicle, huge engine, long step: drive speed and height to the rails
            write_reg(CSR_DRY_MASS, 48'd1);
            write_reg(CSR_PROP_MASS, 48'd65536);
            write_reg(CSR_MAX_THRUST, U48_MAX);
            write_reg(CSR_SPEC_IMP, 48'hFFFF_FFFF);
            write_reg(CSR_GRAVITY, '0);
            write_reg(CSR_TIME_STEP, 48'hFFFF);
         end
         4: begin
            write_reg(CSR_DRY_MASS, U48_MAX);
            write_reg(CSR_PROP_MASS, U48_MAX);
            write_reg(CSR_MAX_THRUST, '0);
            write_reg(CSR_SPEC_IMP, 48'd1);
            write_reg(CSR_GRAVITY, 48'hFF_FFFF);
            write_reg(CSR_TIME_STEP, 48'd1);
         end
         6: begin
            // unused indexes: flight continues from the previous setting
            write_reg(CSR_SPARE_6, rand48());
            write_reg(CSR_SPARE_7, rand48());
         end
         7: begin
            write_reg(CSR_DRY_MASS, rand48());
            write_reg(CSR_PROP_MASS, rand48());
            write_reg(CSR_MAX_THRUST, rand48());
            write_reg(CSR_SPEC_IMP, rand48());
            write_reg(CSR_GRAVITY, rand48());
            write_reg(CSR_TIME_STEP, rand48());
         end
         8: begin
            write_plausible();
            write_reg(CSR_TIME_STEP, spill(48'd0, 16));
         end
         default: write_plausible();
      endcase
      csr_valid <= 1'b0;
   endtask

   // Throttle command followed by a burst of ticks, repeated
   task automatic fly(int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         push_item(ACT_THROTTLE, pick_throttle(), pick_pad());
         left--;
         burst = $urandom_range(0, 8);
         while (burst > 0 && left > 0) begin
            push_item(ACT_TICK, 18'($urandom), pick_pad());
            burst--;
            left--;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: throttle extremes on the power-up settings
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'd131071, 6'd0);
      repeat (4) push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'h20000, 6'd0);
      push_item(ACT_TICK, 18'h3FFFF, 6'h3F);
      push_item(ACT_THROTTLE, 18'd65537, 6'd0);
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'h3FFFF, 6'd0);
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'd1, 6'd0);
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'd65535, 6'd0);
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'd0, 6'h3F);
      push_item(ACT_TICK, 18'd0, 6'd0);
      push_item(ACT_THROTTLE, 18'd65536, 6'd0);
      repeat (2) push_item(ACT_TICK, 18'd0, 6'd0);
      req_tvalid <= 1'b0;
      drain();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         configure(s);
         case (s % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 68; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 68; end
            default: begin idle_pct = 10; stall_pct <= 10; end
         endcase
         fly(ITEMS_EACH);
         drain();
      end

      $display("summary: %0d ticks and %0d throttle commands over %0d register settings",
               tick_count, cmd_count, NUM_SETTINGS + 1);
      $display("summary: %0d register writes, %0d step results compared",
               write_count, compared);
      if (mismatches == 0) begin
         $display("tb_rocket_vertical_euler_step_top: done, clean");
      end else begin
         $display("tb_rocket_vertical_euler_step_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rves_pkg.sv
rtl/core/rocket_vertical_euler_step_top.sv
bench/rves_euler_checker.sv
bench/tb_rocket_vertical_euler_step_top.sv
